FILE: src/stri_pkg.sv
// Shared types and constants for the segment/triangle intersection pipeline.
package stri_pkg;

    localparam int FIELD_W   = 48;         // width of one packed point field
    localparam int IN_W      = 5 * FIELD_W; // request payload width
    localparam int PT_W      = 32;         // width of one output coordinate
    localparam int OUT_W     = 3 * PT_W;   // result payload width
    localparam int TOL_W     = 32;         // width of the tolerance register
    localparam int AREA_FRAC = 16;         // fraction bits of the area test

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd655;

    typedef enum logic [1:0] {
        ST_INSIDE   = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUT_SEG  = 2'd2,
        ST_OUT_TRI  = 2'd3
    } stri_status_t;

endpackage

FILE: src/stri_vlen.sv
// Pipelined vector length: floor of the square root of the squared magnitude.
module stri_vlen #(
    parameter int VW = 54
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [VW-1:0] vec_x,
    input  logic signed [VW-1:0] vec_y,
    input  logic signed [VW-1:0] vec_z,
    output logic [VW:0]          len
);

    localparam int MW   = VW;
    localparam int H    = (MW + 1) / 2;
    localparam int HW   = MW - H;
    localparam int RW   = MW + 1;
    localparam int SW   = 2 * RW;
    localparam int REMW = RW + 2;

    logic signed [VW-1:0] vin [3];
    logic [MW-1:0]   mag_next [3];
    logic [MW-1:0]   mag_reg  [3];
    logic [2*HW-1:0] hh_reg   [3];
    logic [MW-1:0]   hl_reg   [3];
    logic [2*H-1:0]  ll_reg   [3];
    logic [2*MW-1:0] sq_next  [3];
    logic [2*MW-1:0] sq_reg   [3];
    logic [SW-1:0]   rad_reg  [RW+1];
    logic [REMW-1:0] rem_reg  [RW+1];
    logic [RW-1:0]   root_reg [RW+1];
    logic [SW-1:0]   sum_next;

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_next[k] = vin[k][VW-1] ? $unsigned(-vin[k]) : $unsigned(vin[k]);
            sq_next[k]  = ((2*MW)'(hh_reg[k]) << (2*H)) + ((2*MW)'(hl_reg[k]) << (H+1))
                        + (2*MW)'(ll_reg[k]);
        end
        sum_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
    end

    // Squares are split into half-width partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= mag_next[k];
                hh_reg[k]  <= mag_reg[k][MW-1:H] * mag_reg[k][MW-1:H];
                hl_reg[k]  <= mag_reg[k][MW-1:H] * mag_reg[k][H-1:0];
                ll_reg[k]  <= mag_reg[k][H-1:0] * mag_reg[k][H-1:0];
                sq_reg[k]  <= sq_next[k];
            end
            rad_reg[0]  <= sum_next;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // One root bit per stage, restoring method.
    for (genvar i = 1; i <= RW; i++) begin : g_step
        logic [REMW+1:0] rs;
        logic [REMW+1:0] tr;
        logic [SW-1:0]   rad_next;
        logic [REMW-1:0] rem_next;
        logic [RW-1:0]   root_next;

        always_comb begin
            rs       = {rem_reg[i-1], rad_reg[i-1][SW-1 -: 2]};
            tr       = (REMW+2)'({root_reg[i-1], 2'b01});
            rad_next = rad_reg[i-1] << 2;
            if (rs >= tr) begin
                rem_next  = REMW'(rs - tr);
                root_next = {root_reg[i-1][RW-2:0], 1'b1};
            end else begin
                rem_next  = REMW'(rs);
                root_next = {root_reg[i-1][RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[i]  <= rad_next;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign len = root_reg[RW];

endmodule

FILE: src/segment_triangle_intersect_unit.sv
// Top level of the segment/triangle intersection pipeline.
//
// Requests arrive on the s_ stream: five packed points (three triangle
// vertices, segment start, segment end) in s_tdata. Each request produces
// exactly one result on the m_ stream: the hit status in m_tuser and the
// intersection point (x, y, z, 16.16 style fixed point with FRAC_BITS
// fraction bits) in m_tdata. Results leave in request order.
// The block is a fixed-length pipeline that takes a new request every
// cycle while the output is not stalled. The length is set by the
// quotient stages (one bit each) and by the square-root units (one root
// bit each, COORD_BITS*2 + 23 bits). When the receiver stalls, the
// result stays in the output register and the whole pipeline holds; the
// input stage still takes a request while it is empty. Reset clears every
// valid bit and loads area_tolerance with 655. The user must write the
// tolerance through cfg_we/cfg_wdata only while idle; the block does not
// enforce this.
module segment_triangle_intersect_unit
    import stri_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [TOL_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // tri_vertex_a, tri_vertex_b, tri_vertex_c, seg_start, seg_end (48 bits each)
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // point_x, point_y, point_z (32 bits each)
    output logic [OUT_W-1:0] m_tdata,
    // hit_status
    output logic [1:0]       m_tuser
);

    localparam int CB    = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = (3 * CB > FIELD_W) ? 3 * CB : FIELD_W;
    localparam int DW    = CB + 1;
    localparam int NW    = 2 * DW + 1;
    localparam int DTW   = NW + DW + 2;
    localparam int QW    = F + 1;
    localparam int T16W  = AREA_FRAC + 1;
    localparam int VW    = NW + T16W + 2;
    localparam int RW    = VW + 1;
    localparam int VLAT  = RW + 4;
    localparam int SW    = RW + 2;
    localparam int PTW0  = DW + QW + 2;
    localparam int PTW   = (PTW0 > PT_W + 1) ? PTW0 : PT_W + 1;
    localparam int NSTG  = 11 + F + VLAT;

    typedef struct packed { logic signed [CB-1:0] x, y, z; } cvec_t;
    typedef struct packed { logic signed [DW-1:0] x, y, z; } dvec_t;
    typedef struct packed { logic signed [NW-1:0] x, y, z; } nvec_t;
    typedef struct packed { logic signed [VW-1:0] x, y, z; } vvec_t;
    typedef struct packed { logic signed [DW+QW:0] x, y, z; } pvec_t;
    typedef struct packed { logic signed [PTW-1:0] x, y, z; } ptvec_t;

    typedef struct packed {
        cvec_t s;
        dvec_t d, e0, e1, e2, fab, fbc, fca;
        nvec_t n;
    } geo_t;

    typedef struct packed { cvec_t a, b, c, s, e; } in_t;
    typedef struct packed { dvec_t ab; geo_t g; } s1_t;
    typedef struct packed { logic signed [DTW-1:0] den, num; geo_t g; } s3_t;
    typedef struct packed {
        logic signed [DTW-1:0] den, num;
        logic                  zero;
        geo_t                  g;
    } s4_t;
    typedef struct packed {
        stri_status_t   stat;
        logic           eq;
        logic [DTW-1:0] den;
        logic [DTW:0]   r;
        logic [QW-1:0]  q;
        geo_t           g;
    } dv_t;
    typedef struct packed { stri_status_t stat; logic [QW-1:0] q; geo_t g; } rq_t;
    typedef struct packed {
        stri_status_t    stat;
        logic [T16W-1:0] t16;
        pvec_t           pm;
        cvec_t           s;
        nvec_t           x0, x1, x2, y0, y1, y2, n;
    } tq_t;
    typedef struct packed {
        stri_status_t stat;
        ptvec_t       pt;
        vvec_t        v0, v1, v2, w;
    } uq_t;
    typedef struct packed {
        stri_status_t    stat;
        logic [PT_W-1:0] px, py, pz;
    } side_t;
    typedef struct packed { side_t sd; logic [SW-1:0] sum; logic [RW-1:0] whole; } c1_t;
    typedef struct packed { side_t sd; logic ge; logic [SW-1:0] da, db; } c2_t;

    localparam logic [QW-1:0] ONE_Q = {1'b1, {F{1'b0}}};
    localparam logic signed [PTW-1:0] PT_MAX = {{(PTW-PT_W+1){1'b0}}, {(PT_W-1){1'b1}}};
    localparam logic signed [PTW-1:0] PT_MIN = {{(PTW-PT_W+1){1'b1}}, {(PT_W-1){1'b0}}};

    function automatic cvec_t unpack(input logic [FIELD_W-1:0] f);
        logic [PW-1:0] p;
        cvec_t r;
        p   = PW'(f);
        r.x = p[0 +: CB];
        r.y = p[CB +: CB];
        r.z = p[2*CB +: CB];
        return r;
    endfunction

    function automatic dvec_t csub(input cvec_t a, input cvec_t b);
        dvec_t r;
        r.x = DW'(a.x) - DW'(b.x);
        r.y = DW'(a.y) - DW'(b.y);
        r.z = DW'(a.z) - DW'(b.z);
        return r;
    endfunction

    function automatic nvec_t dcross(input dvec_t a, input dvec_t b);
        logic signed [2*DW-1:0] p0, p1, p2, p3, p4, p5;
        nvec_t r;
        p0  = a.y * b.z;
        p1  = a.z * b.y;
        p2  = a.z * b.x;
        p3  = a.x * b.z;
        p4  = a.x * b.y;
        p5  = a.y * b.x;
        r.x = NW'(p0) - NW'(p1);
        r.y = NW'(p2) - NW'(p3);
        r.z = NW'(p4) - NW'(p5);
        return r;
    endfunction

    function automatic logic signed [DTW-1:0] ndot(input nvec_t n, input dvec_t d);
        logic signed [NW+DW-1:0] p0, p1, p2;
        p0 = n.x * d.x;
        p1 = n.y * d.y;
        p2 = n.z * d.z;
        return DTW'(p0) + DTW'(p1) + DTW'(p2);
    endfunction

    // Scaled cross vector of one sub-triangle: x * 2^16 + y * t16.
    function automatic vvec_t area_vec(input nvec_t x, input nvec_t y,
                                       input logic [T16W-1:0] t);
        logic signed [T16W:0]    ts;
        logic signed [NW+T16W:0] px, py, pz;
        vvec_t r;
        ts  = $signed({1'b0, t});
        px  = y.x * ts;
        py  = y.y * ts;
        pz  = y.z * ts;
        r.x = (VW'(x.x) <<< AREA_FRAC) + VW'(px);
        r.y = (VW'(x.y) <<< AREA_FRAC) + VW'(py);
        r.z = (VW'(x.z) <<< AREA_FRAC) + VW'(pz);
        return r;
    endfunction

    function automatic logic [PT_W-1:0] sat32(input logic signed [PTW-1:0] v);
        logic [PT_W-1:0] r;
        if (v > PT_MAX) begin
            r = PT_MAX[PT_W-1:0];
        end else if (v < PT_MIN) begin
            r = PT_MIN[PT_W-1:0];
        end else begin
            r = v[PT_W-1:0];
        end
        return r;
    endfunction

    // Pipeline control. A stalled output freezes every stage; the input
    // stage alone may still fill while it is empty.
    logic en;
    logic ld0;
    logic in_v_reg;
    logic [NSTG-1:0] vpipe_reg;
    logic [TOL_W-1:0] tol_reg;

    assign en       = !vpipe_reg[NSTG-1] || m_tready;
    assign ld0      = en || !in_v_reg;
    assign s_tready = ld0;
    assign m_tvalid = vpipe_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            vpipe_reg <= '0;
            tol_reg   <= TOL_RESET;
        end else begin
            if (ld0) begin
                in_v_reg <= s_tvalid;
            end
            if (en) begin
                vpipe_reg <= {vpipe_reg[NSTG-2:0], in_v_reg};
            end
            if (cfg_we) begin
                tol_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers, one per stage.
    in_t   in_reg, in_next;
    s1_t   s1_reg, s1_next;
    geo_t  s2_reg, s2_next;
    s3_t   s3_reg, s3_next;
    s4_t   s4_reg, s4_next;
    dv_t   dv_reg [F+1];
    dv_t   dv0_next;
    rq_t   rq_reg, rq_next;
    tq_t   tq_reg, tq_next;
    uq_t   uq_reg, uq_next;
    side_t sd_reg [VLAT];
    side_t sd0_next;
    c1_t   c1_reg, c1_next;
    c2_t   c2_reg, c2_next;
    side_t out_reg, out_next;
    logic [T16W-1:0] t16_next;
    logic [RW-1:0] len0, len1, len2, lenw;

    always_comb begin
        in_next.a = unpack(s_tdata[0*FIELD_W +: FIELD_W]);
        in_next.b = unpack(s_tdata[1*FIELD_W +: FIELD_W]);
        in_next.c = unpack(s_tdata[2*FIELD_W +: FIELD_W]);
        in_next.s = unpack(s_tdata[3*FIELD_W +: FIELD_W]);
        in_next.e = unpack(s_tdata[4*FIELD_W +: FIELD_W]);

        // Edge and offset vectors.
        s1_next.ab    = csub(in_reg.b, in_reg.a);
        s1_next.g.s   = in_reg.s;
        s1_next.g.d   = csub(in_reg.e, in_reg.s);
        s1_next.g.e0  = csub(in_reg.a, in_reg.s);
        s1_next.g.e1  = csub(in_reg.b, in_reg.s);
        s1_next.g.e2  = csub(in_reg.c, in_reg.s);
        s1_next.g.fab = csub(in_reg.a, in_reg.b);
        s1_next.g.fbc = csub(in_reg.b, in_reg.c);
        s1_next.g.fca = csub(in_reg.c, in_reg.a);
        s1_next.g.n   = '0;

        // Plane normal.
        s2_next   = s1_reg.g;
        s2_next.n = dcross(s1_reg.ab, s1_reg.g.fca);

        s3_next.den = ndot(s2_reg.n, s2_reg.d);
        s3_next.num = ndot(s2_reg.n, s2_reg.e0);
        s3_next.g   = s2_reg;

        // Make the denominator positive.
        s4_next.zero = (s3_reg.den == '0);
        s4_next.den  = s3_reg.den[DTW-1] ? -s3_reg.den : s3_reg.den;
        s4_next.num  = s3_reg.den[DTW-1] ? -s3_reg.num : s3_reg.num;
        s4_next.g    = s3_reg.g;

        if (s4_reg.zero) begin
            dv0_next.stat = ST_PARALLEL;
        end else if (s4_reg.num[DTW-1] || (s4_reg.num > s4_reg.den)) begin
            dv0_next.stat = ST_OUT_SEG;
        end else begin
            dv0_next.stat = ST_INSIDE;
        end
        dv0_next.eq  = (s4_reg.num == s4_reg.den);
        dv0_next.den = $unsigned(s4_reg.den);
        dv0_next.r   = {1'b0, $unsigned(s4_reg.num)};
        dv0_next.q   = '0;
        dv0_next.g   = s4_reg.g;

        // Round the quotient half up; t equal to one is exact.
        rq_next.stat = dv_reg[F].stat;
        rq_next.g    = dv_reg[F].g;
        if (dv_reg[F].eq) begin
            rq_next.q = ONE_Q;
        end else if ({dv_reg[F].r, 1'b0} >= {2'b00, dv_reg[F].den}) begin
            rq_next.q = dv_reg[F].q + QW'(1);
        end else begin
            rq_next.q = dv_reg[F].q;
        end

        tq_next.stat = rq_reg.stat;
        tq_next.t16  = t16_next;
        tq_next.pm.x = rq_reg.g.d.x * $signed({1'b0, rq_reg.q});
        tq_next.pm.y = rq_reg.g.d.y * $signed({1'b0, rq_reg.q});
        tq_next.pm.z = rq_reg.g.d.z * $signed({1'b0, rq_reg.q});
        tq_next.s    = rq_reg.g.s;
        tq_next.x0   = dcross(rq_reg.g.e0, rq_reg.g.e1);
        tq_next.x1   = dcross(rq_reg.g.e1, rq_reg.g.e2);
        tq_next.x2   = dcross(rq_reg.g.e2, rq_reg.g.e0);
        tq_next.y0   = dcross(rq_reg.g.d, rq_reg.g.fab);
        tq_next.y1   = dcross(rq_reg.g.d, rq_reg.g.fbc);
        tq_next.y2   = dcross(rq_reg.g.d, rq_reg.g.fca);
        tq_next.n    = rq_reg.g.n;

        uq_next.stat = tq_reg.stat;
        uq_next.pt.x = (PTW'(tq_reg.s.x) <<< F) + PTW'(tq_reg.pm.x);
        uq_next.pt.y = (PTW'(tq_reg.s.y) <<< F) + PTW'(tq_reg.pm.y);
        uq_next.pt.z = (PTW'(tq_reg.s.z) <<< F) + PTW'(tq_reg.pm.z);
        uq_next.v0   = area_vec(tq_reg.x0, tq_reg.y0, tq_reg.t16);
        uq_next.v1   = area_vec(tq_reg.x1, tq_reg.y1, tq_reg.t16);
        uq_next.v2   = area_vec(tq_reg.x2, tq_reg.y2, tq_reg.t16);
        uq_next.w.x  = VW'(tq_reg.n.x) <<< AREA_FRAC;
        uq_next.w.y  = VW'(tq_reg.n.y) <<< AREA_FRAC;
        uq_next.w.z  = VW'(tq_reg.n.z) <<< AREA_FRAC;

        // Parallel and off-segment results carry a zero point.
        sd0_next.stat = uq_reg.stat;
        if (uq_reg.stat == ST_INSIDE) begin
            sd0_next.px = sat32(uq_reg.pt.x);
            sd0_next.py = sat32(uq_reg.pt.y);
            sd0_next.pz = sat32(uq_reg.pt.z);
        end else begin
            sd0_next.px = '0;
            sd0_next.py = '0;
            sd0_next.pz = '0;
        end

        c1_next.sd    = sd_reg[VLAT-1];
        c1_next.sum   = SW'(len0) + SW'(len1) + SW'(len2);
        c1_next.whole = lenw;

        c2_next.sd = c1_reg.sd;
        c2_next.ge = c1_reg.sum >= SW'(c1_reg.whole);
        c2_next.da = c1_reg.sum - SW'(c1_reg.whole);
        c2_next.db = SW'(c1_reg.whole) - c1_reg.sum;

        out_next = c2_reg.sd;
        if (c2_reg.sd.stat == ST_INSIDE) begin
            if ((c2_reg.ge ? c2_reg.da : c2_reg.db) <= SW'(tol_reg)) begin
                out_next.stat = ST_INSIDE;
            end else begin
                out_next.stat = ST_OUT_TRI;
            end
        end
    end

    // t rescaled to the 16 fraction bits of the area test.
    if (F > AREA_FRAC) begin : g_t16_round
        localparam int SH = F - AREA_FRAC;
        logic [QW:0] qr;
        assign qr       = {1'b0, rq_reg.q} + ((QW+1)'(1) << (SH - 1));
        assign t16_next = T16W'(qr >> SH);
    end else if (F == AREA_FRAC) begin : g_t16_same
        assign t16_next = T16W'(rq_reg.q);
    end else begin : g_t16_widen
        assign t16_next = T16W'({rq_reg.q, {(AREA_FRAC - F){1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (ld0) begin
            in_reg <= in_next;
        end
        if (en) begin
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            s3_reg    <= s3_next;
            s4_reg    <= s4_next;
            dv_reg[0] <= dv0_next;
            rq_reg    <= rq_next;
            tq_reg    <= tq_next;
            uq_reg    <= uq_next;
            sd_reg[0] <= sd0_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            out_reg   <= out_next;
        end
    end

    // Quotient stages: one bit of num/den per stage.
    for (genvar k = 1; k <= F; k++) begin : g_div
        logic [DTW:0] r2;
        logic         ge;
        dv_t          dv_next;

        always_comb begin
            r2            = {dv_reg[k-1].r[DTW-1:0], 1'b0};
            ge            = r2 >= {1'b0, dv_reg[k-1].den};
            dv_next       = dv_reg[k-1];
            dv_next.r     = ge ? r2 - {1'b0, dv_reg[k-1].den} : r2;
            dv_next.q     = {dv_reg[k-1].q[QW-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[k] <= dv_next;
            end
        end
    end

    // Sideband delay that matches the square-root units.
    for (genvar j = 1; j < VLAT; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                sd_reg[j] <= sd_reg[j-1];
            end
        end
    end

    stri_vlen #(.VW(VW)) u_len0 (
        .aclk(aclk), .en(en),
        .vec_x(uq_reg.v0.x), .vec_y(uq_reg.v0.y), .vec_z(uq_reg.v0.z), .len(len0)
    );
    stri_vlen #(.VW(VW)) u_len1 (
        .aclk(aclk), .en(en),
        .vec_x(uq_reg.v1.x), .vec_y(uq_reg.v1.y), .vec_z(uq_reg.v1.z), .len(len1)
    );
    stri_vlen #(.VW(VW)) u_len2 (
        .aclk(aclk), .en(en),
        .vec_x(uq_reg.v2.x), .vec_y(uq_reg.v2.y), .vec_z(uq_reg.v2.z), .len(len2)
    );
    stri_vlen #(.VW(VW)) u_lenw (
        .aclk(aclk), .en(en),
        .vec_x(uq_reg.w.x), .vec_y(uq_reg.w.y), .vec_z(uq_reg.w.z), .len(lenw)
    );

    assign m_tdata = {out_reg.pz, out_reg.py, out_reg.px};
    assign m_tuser = out_reg.stat;

`ifndef NO_ASSERTIONS
    // A parallel or off-segment result never carries a point.
    a_zero_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_PARALLEL || m_tuser == ST_OUT_SEG) |-> m_tdata == '0)
        else $error("point not zero for a parallel or off-segment result");

    // The input side is refused only while a result is held at the output.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input refused without an output stall");

    // A stall freezes every valid bit inside the pipeline.
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> vpipe_reg == $past(vpipe_reg))
        else $error("pipeline moved during an output stall");

    // The rounded ratio of a candidate hit never exceeds one.
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vpipe_reg[5 + F] && rq_reg.stat == ST_INSIDE |-> rq_reg.q <= ONE_Q)
        else $error("segment ratio above one");
`endif

endmodule
